### hw/rtl/phm_pkg.sv
`default_nettype none
package phm_pkg;
  localparam int unsigned TableDepth = 1024;
  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned MaxStrokes = 4;
  localparam int unsigned StrokeBits = 24;
  localparam int unsigned ProbeLimit = 64;
  localparam int unsigned ProbeW = $clog2(TableDepth + 1);
  localparam logic [16:0] DataBytes = 17'd65536;
  localparam logic [3:0] SizeLog2Max = 4'(IdxW);
  localparam logic [3:0] SizeLog2Reset = 4'd10;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_NO_SPACE  = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    TAG_EMPTY   = 2'd0,
    TAG_DELETED = 2'd1,
    TAG_USED    = 2'd2
  } tag_e;

  localparam logic CfgSizeIdx = 1'b0;
  localparam logic CfgCapIdx  = 1'b1;

  typedef struct packed {
    logic load;
    logic clr_step;
    logic clr_start;
    logic rd;
    logic advance;
    logic wr_used;
    logic wr_deleted;
    logic reserve;
    logic clear_regs;
    logic [1:0] result;
  } phm_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic no_space;
    logic [1:0] tag;
    logic match;
    logic probe_done;
    logic clr_done;
  } phm_stat_t;
endpackage
`default_nettype wire

### hw/rtl/phm_datapath.sv
`default_nettype none
module phm_datapath (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire phm_pkg::phm_cmd_t          cmd_i,
  output phm_pkg::phm_stat_t              stat_o,
  input  wire logic                       cfg_we_i,
  input  wire logic                       cfg_idx_i,
  input  wire logic [16:0]                cfg_data_i,
  input  wire logic [1:0]                 op_i,
  input  wire logic [31:0]                key_hash_i,
  input  wire logic [2:0]                 key_length_i,
  input  wire logic [23:0]                stroke_a_i,
  input  wire logic [23:0]                stroke_b_i,
  input  wire logic [23:0]                stroke_c_i,
  input  wire logic [23:0]                stroke_d_i,
  input  wire logic [9:0]                 text_length_i,
  output logic [1:0]                      status_o,
  output logic [15:0]                     record_offset_o,
  output logic [2:0]                      longest_key_o
);
  localparam int unsigned IW = phm_pkg::IdxW;
  localparam int unsigned KW = phm_pkg::MaxStrokes * phm_pkg::StrokeBits + 3;

  logic [3:0] size_log2_q;
  logic [16:0] capacity_q, free_q, rec_q;
  logic [2:0] longest_q;
  logic [1:0] op_q;
  logic [2:0] len_q;
  logic [phm_pkg::MaxStrokes*phm_pkg::StrokeBits-1:0] strokes_q;
  logic [9:0] text_q;
  logic [IW-1:0] idx_q, mask_q, clr_q;
  logic [phm_pkg::ProbeW-1:0] cnt_q, limit_q;

  logic [1:0] tag_mem [phm_pkg::TableDepth];
  logic [15:0] off_mem [phm_pkg::TableDepth];
  logic [KW-1:0] key_mem [phm_pkg::TableDepth];
  logic [1:0] tag_rd_q;
  logic [15:0] off_rd_q;
  logic [KW-1:0] key_rd_q;

  logic [2:0] len_sat;
  logic [3:0] lg;
  logic [IW:0] slots;
  logic [phm_pkg::MaxStrokes*phm_pkg::StrokeBits-1:0] key_in;
  logic [17:0] size_w;
  logic [16:0] rec_new;

  always_comb begin
    len_sat = (key_length_i > 3'(phm_pkg::MaxStrokes)) ? 3'(phm_pkg::MaxStrokes)
                                                      : key_length_i;
    lg = (size_log2_q > phm_pkg::SizeLog2Max) ? phm_pkg::SizeLog2Max : size_log2_q;
    slots = (IW+1)'(1) << lg;
    key_in = {(len_sat > 3'd3) ? stroke_d_i : 24'd0,
              (len_sat > 3'd2) ? stroke_c_i : 24'd0,
              (len_sat > 3'd1) ? stroke_b_i : 24'd0,
              (len_sat > 3'd0) ? stroke_a_i : 24'd0};
    size_w = 18'd4 + {13'd0, len_q, 2'd0} + {6'd0, (12'(text_q) + 12'd4) & ~12'd3};
    rec_new = free_q - size_w[16:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_log2_q <= phm_pkg::SizeLog2Reset;
      capacity_q  <= phm_pkg::DataBytes;
      free_q      <= phm_pkg::DataBytes;
      longest_q   <= 3'd0;
      clr_q       <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == phm_pkg::CfgSizeIdx) size_log2_q <= cfg_data_i[3:0];
      if (cfg_we_i && cfg_idx_i == phm_pkg::CfgCapIdx) capacity_q <= cfg_data_i;
      if (cmd_i.clr_start) clr_q <= '0;
      else if (cmd_i.clr_step) clr_q <= clr_q + 1'b1;
      if (cmd_i.clear_regs) begin
        free_q <= capacity_q;
        longest_q <= 3'd0;
      end else if (cmd_i.reserve) begin
        free_q <= rec_new;
        if (len_q > longest_q) longest_q <= len_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= op_i;
      len_q <= len_sat;
      strokes_q <= key_in;
      text_q <= text_length_i;
      idx_q <= key_hash_i[IW-1:0] & IW'(slots - 1'b1);
      mask_q <= IW'(slots - 1'b1);
      limit_q <= (op_i == phm_pkg::OP_INSERT) ? phm_pkg::ProbeW'(phm_pkg::ProbeLimit)
                                              : phm_pkg::ProbeW'(slots);
      cnt_q <= '0;
    end else if (cmd_i.advance) begin
      idx_q <= (idx_q + 1'b1) & mask_q;
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.reserve) rec_q <= rec_new;
    if (cmd_i.clr_step) tag_mem[clr_q] <= phm_pkg::TAG_EMPTY;
    else if (cmd_i.wr_used) tag_mem[idx_q] <= phm_pkg::TAG_USED;
    else if (cmd_i.wr_deleted) tag_mem[idx_q] <= phm_pkg::TAG_DELETED;
    if (cmd_i.wr_used) begin
      off_mem[idx_q] <= rec_q[15:0];
      key_mem[idx_q] <= {len_q, strokes_q};
    end
    if (cmd_i.rd) begin
      tag_rd_q <= tag_mem[idx_q];
      off_rd_q <= off_mem[idx_q];
      key_rd_q <= key_mem[idx_q];
    end
    // result register
    if (cmd_i.result != 2'd0) begin
      longest_key_o <= cmd_i.clear_regs ? 3'd0 : longest_q;
      case (cmd_i.result)
        2'd1: begin
          status_o <= phm_pkg::ST_OK;
          record_offset_o <= (op_q == phm_pkg::OP_INSERT) ? rec_q[15:0] : off_rd_q;
        end
        2'd2: begin
          status_o <= phm_pkg::ST_NOT_FOUND;
          record_offset_o <= 16'd0;
        end
        default: begin
          // clear: ok; lookup/remove: not found; insert: probes used up means table full, else the space check failed
          status_o <= (op_q == phm_pkg::OP_CLEAR) ? phm_pkg::ST_OK :
                      (op_q != phm_pkg::OP_INSERT) ? phm_pkg::ST_NOT_FOUND :
                      (cnt_q == limit_q) ? phm_pkg::ST_FULL : phm_pkg::ST_NO_SPACE;
          record_offset_o <= 16'd0;
        end
      endcase
    end
  end

  always_comb begin
    stat_o.op = op_q;
    stat_o.no_space = size_w[17] || (free_q < size_w[16:0]);
    stat_o.tag = tag_rd_q;
    stat_o.match = (key_rd_q == {len_q, strokes_q});
    stat_o.probe_done = (cnt_q == limit_q);
    stat_o.clr_done = (clr_q == IW'(phm_pkg::TableDepth - 1));
  end
endmodule
`default_nettype wire

### hw/rtl/phm_ctrl.sv
`default_nettype none
module phm_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  input  wire phm_pkg::phm_stat_t stat_i,
  output phm_pkg::phm_cmd_t       cmd_o
);
  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_START, S_READ, S_EVAL, S_CLEAR, S_DONE
  } state_e;
  state_e state_q;
  logic out_busy;

  assign out_busy = out_valid_o && !out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && !out_busy;

  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_INIT: cmd_o.clr_step = 1'b1;
      S_IDLE: cmd_o.load = in_valid_i && in_ready_o;
      S_START: begin
        if (stat_i.op == phm_pkg::OP_CLEAR) cmd_o.clr_start = 1'b1;
        else if (stat_i.op == phm_pkg::OP_INSERT && !stat_i.no_space)
          cmd_o.reserve = 1'b1;
      end
      S_READ: if (!stat_i.probe_done) cmd_o.rd = 1'b1;
      S_EVAL: begin
        if (stat_i.op == phm_pkg::OP_INSERT) begin
          if (stat_i.tag != phm_pkg::TAG_USED || stat_i.match) cmd_o.wr_used = 1'b1;
          else cmd_o.advance = 1'b1;
        end else if (stat_i.tag != phm_pkg::TAG_EMPTY) begin
          if (stat_i.tag == phm_pkg::TAG_USED && stat_i.match) begin
            if (stat_i.op == phm_pkg::OP_REMOVE) cmd_o.wr_deleted = 1'b1;
          end else cmd_o.advance = 1'b1;
        end
      end
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_done) cmd_o.clear_regs = 1'b1;
      end
      default: ;
    endcase
    // result codes: 1 hit, 2 miss, 3 special
    if (state_q == S_START && (stat_i.op == phm_pkg::OP_INSERT && stat_i.no_space))
      cmd_o.result = 2'd3;
    if (state_q == S_READ && stat_i.probe_done) cmd_o.result = 2'd3;
    if (state_q == S_CLEAR && stat_i.clr_done) cmd_o.result = 2'd3;
    if (state_q == S_EVAL) begin
      if (cmd_o.wr_used || cmd_o.wr_deleted ||
          (stat_i.op != phm_pkg::OP_INSERT && stat_i.tag == phm_pkg::TAG_USED &&
           stat_i.match)) cmd_o.result = 2'd1;
      else if (stat_i.op != phm_pkg::OP_INSERT && stat_i.tag == phm_pkg::TAG_EMPTY)
        cmd_o.result = 2'd2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      out_valid_o <= 1'b0;
    end else begin
      if (cmd_o.result != 2'd0) out_valid_o <= 1'b1;
      else if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      case (state_q)
        S_INIT: if (stat_i.clr_done) state_q <= S_IDLE;
        S_IDLE: if (cmd_o.load) state_q <= S_START;
        S_START: begin
          if (stat_i.op == phm_pkg::OP_CLEAR) state_q <= S_CLEAR;
          else if (cmd_o.result != 2'd0) state_q <= S_IDLE;
          else state_q <= S_READ;
        end
        S_READ: state_q <= stat_i.probe_done ? S_IDLE : S_EVAL;
        S_EVAL: state_q <= cmd_o.advance ? S_READ : S_IDLE;
        S_CLEAR: if (stat_i.clr_done) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### hw/rtl/probed_hash_map_with_tombstones.sv
// a result is given on a hit or an empty slot, when the probe limit or a full pass
// runs out, for a no-space insert, and for clear after one sweep of the tag table
// throughput: one transaction at a time; the next is taken once the result is taken
// reset: after rst_ni rises the tag table is swept empty before the first
// transaction is taken; config writes are taken throughout
`default_nettype none
module probed_hash_map_with_tombstones (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [31:0] key_hash_i,
  input  wire logic [2:0]  key_length_i,
  input  wire logic [23:0] stroke_a_i,
  input  wire logic [23:0] stroke_b_i,
  input  wire logic [23:0] stroke_c_i,
  input  wire logic [23:0] stroke_d_i,
  input  wire logic [9:0]  text_length_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic [15:0]      record_offset_o,
  output logic [2:0]       longest_key_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [0:0]  cfg_index_i,
  input  wire logic [16:0] cfg_data_i
);
  phm_pkg::phm_cmd_t cmd;
  phm_pkg::phm_stat_t stat;

  // config is always accepted
  assign cfg_ready_o = 1'b1;

  phm_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .stat_i(stat), .cmd_o(cmd)
  );

  phm_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .cfg_we_i(cfg_valid_i), .cfg_idx_i(cfg_index_i[0]), .cfg_data_i,
    .op_i, .key_hash_i, .key_length_i, .stroke_a_i, .stroke_b_i, .stroke_c_i,
    .stroke_d_i, .text_length_i, .status_o, .record_offset_o, .longest_key_o
  );
endmodule
`default_nettype wire

### hw/rtl/phm_checker.sv
`default_nettype none
module phm_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_o,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire logic [1:0] status_o,
  input wire logic [15:0] record_offset_o,
  input wire logic [2:0] longest_key_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("result dropped");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transaction taken while busy");
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != 2'd0 |-> record_offset_o == 16'd0)
    else $error("offset on failure");
  a_longest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> longest_key_o <= 3'd4)
    else $error("longest key out of range");
endmodule
bind probed_hash_map_with_tombstones phm_checker u_phm_checker (.*);
`default_nettype wire
